FILE: rtl/core/chacha20_keystream_xor_macros.svh
// ---------------------------------------------------------------------------
// chacha20_keystream_xor_macros.svh
// Assertion macros shared by the keystream XOR RTL.
// ---------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted
`define CC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define CC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CC_ASSERT(lbl, prop, msg)
`define CC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/core/cc20_pkg.sv
// ---------------------------------------------------------------------------
// cc20_pkg
// Shared constants, types and helper functions for the ChaCha20 keystream
// XOR block.
// ---------------------------------------------------------------------------
package cc20_pkg;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int NUM_WORDS  = 16;
  localparam int NUM_LANES  = 4;
  localparam int NUM_ROUNDS = 20;
  localparam int RND_W      = 5;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(NUM_ROUNDS - 1);
  localparam logic [1:0]       STP_LAST = 2'd3;

  // Control from the stream side into the round engine
  typedef struct packed {
    logic        start;
    logic [31:0] key;
    logic [31:0] ctr;
  } cc_ctl_t;

  // Status from the round engine
  typedef struct packed {
    logic busy;
  } cc_sts_t;

  // Initial cipher state word: constants, expanded key, counter, zero nonce
  function automatic logic [31:0] init_word(input logic [3:0]  idx,
                                            input logic [31:0] key,
                                            input logic [31:0] ctr);
    logic [31:0] w;
    case (idx)
      4'd0:    w = SIGMA0;
      4'd1:    w = SIGMA1;
      4'd2:    w = SIGMA2;
      4'd3:    w = SIGMA3;
      4'd4:    w = key ^ (key >> 1);
      4'd5:    w = key ^ (key >> 5);
      4'd6:    w = key ^ (key >> 9);
      4'd7:    w = key ^ (key >> 13);
      4'd8:    w = key ^ (key >> 17);
      4'd9:    w = key ^ (key >> 21);
      4'd10:   w = key ^ (key >> 25);
      4'd11:   w = key ^ (key >> 29);
      4'd12:   w = ctr;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/cc20_core.sv
// ---------------------------------------------------------------------------
// cc20_core
// Iterative ChaCha20 block engine: four quarter-round lanes advance one
// add/xor/rotate step per cycle, then the same adders do the feed-forward.
// ---------------------------------------------------------------------------
module cc20_core (
  input  logic             clk,
  input  logic             rst_n,
  input  cc20_pkg::cc_ctl_t ctl,
  output cc20_pkg::cc_sts_t sts,
  input  logic [5:0]       rd_pos,   // keystream byte index
  output logic [7:0]       rd_byte   // keystream byte at rd_pos
);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_ROUND = 3'b010,
    CS_FEED  = 3'b100
  } cs_t;

  cs_t                          cs_r, cs_nxt;
  logic [cc20_pkg::RND_W-1:0]   rnd_r, rnd_nxt;
  logic [1:0]                   stp_r, stp_nxt;
  logic [31:0]                  key_r, key_nxt;
  logic [31:0]                  ctr_r, ctr_nxt;
  logic [31:0]                  w_r   [cc20_pkg::NUM_WORDS];
  logic [31:0]                  w_nxt [cc20_pkg::NUM_WORDS];

  // Per-lane word indices and shared adder
  logic [3:0]  ia [cc20_pkg::NUM_LANES];
  logic [3:0]  ib [cc20_pkg::NUM_LANES];
  logic [3:0]  ic [cc20_pkg::NUM_LANES];
  logic [3:0]  id [cc20_pkg::NUM_LANES];
  logic [31:0] add_a [cc20_pkg::NUM_LANES];
  logic [31:0] add_b [cc20_pkg::NUM_LANES];
  logic [31:0] sum   [cc20_pkg::NUM_LANES];
  logic [31:0] mix   [cc20_pkg::NUM_LANES];
  logic [31:0] rot   [cc20_pkg::NUM_LANES];
  logic        diag;

  assign diag = rnd_r[0];

  // Column rounds use rows as is; diagonal rounds shift rows b, c, d
  always_comb begin
    for (int j = 0; j < cc20_pkg::NUM_LANES; j++) begin
      ia[j] = {2'b00, 2'(j)};
      ib[j] = {2'b01, 2'(j) + {1'b0, diag}};
      ic[j] = {2'b10, 2'(j) + {diag, 1'b0}};
      id[j] = {2'b11, 2'(j) + {diag, diag}};
    end
  end

  // Operand select for the lane adders, xor and fixed rotation
  always_comb begin
    for (int j = 0; j < cc20_pkg::NUM_LANES; j++) begin
      if (cs_r == CS_FEED) begin
        add_a[j] = w_r[{stp_r, 2'(j)}];
        add_b[j] = cc20_pkg::init_word({stp_r, 2'(j)}, key_r, ctr_r);
      end else if (stp_r[0]) begin
        add_a[j] = w_r[ic[j]];
        add_b[j] = w_r[id[j]];
      end else begin
        add_a[j] = w_r[ia[j]];
        add_b[j] = w_r[ib[j]];
      end
      sum[j] = add_a[j] + add_b[j];
      mix[j] = (stp_r[0] ? w_r[ib[j]] : w_r[id[j]]) ^ sum[j];
      case (stp_r)
        2'd0:    rot[j] = {mix[j][15:0], mix[j][31:16]};
        2'd1:    rot[j] = {mix[j][19:0], mix[j][31:20]};
        2'd2:    rot[j] = {mix[j][23:0], mix[j][31:24]};
        default: rot[j] = {mix[j][24:0], mix[j][31:25]};
      endcase
    end
  end

  // Sequencer and state word update
  always_comb begin
    cs_nxt  = cs_r;
    rnd_nxt = rnd_r;
    stp_nxt = stp_r;
    key_nxt = key_r;
    ctr_nxt = ctr_r;
    w_nxt   = w_r;
    unique case (cs_r)
      CS_IDLE: begin
        if (ctl.start) begin
          key_nxt = ctl.key;
          ctr_nxt = ctl.ctr;
          for (int i = 0; i < cc20_pkg::NUM_WORDS; i++) begin
            w_nxt[i] = cc20_pkg::init_word(4'(i), ctl.key, ctl.ctr);
          end
          rnd_nxt = '0;
          stp_nxt = '0;
          cs_nxt  = CS_ROUND;
        end
      end
      CS_ROUND: begin
        for (int j = 0; j < cc20_pkg::NUM_LANES; j++) begin
          if (stp_r[0]) begin
            w_nxt[ic[j]] = sum[j];
            w_nxt[ib[j]] = rot[j];
          end else begin
            w_nxt[ia[j]] = sum[j];
            w_nxt[id[j]] = rot[j];
          end
        end
        stp_nxt = stp_r + 2'd1;
        if (stp_r == cc20_pkg::STP_LAST) begin
          if (rnd_r == cc20_pkg::RND_LAST) begin
            rnd_nxt = '0;
            cs_nxt  = CS_FEED;
          end else begin
            rnd_nxt = rnd_r + cc20_pkg::RND_W'(1);
          end
        end
      end
      CS_FEED: begin
        for (int j = 0; j < cc20_pkg::NUM_LANES; j++) begin
          w_nxt[{stp_r, 2'(j)}] = sum[j];
        end
        stp_nxt = stp_r + 2'd1;
        if (stp_r == cc20_pkg::STP_LAST) begin
          cs_nxt = CS_IDLE;
        end
      end
      default: cs_nxt = CS_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= CS_IDLE;
      rnd_r <= '0;
      stp_r <= '0;
    end else begin
      cs_r  <= cs_nxt;
      rnd_r <= rnd_nxt;
      stp_r <= stp_nxt;
    end
  end

  // Cipher state and latched block inputs
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ctr_r <= ctr_nxt;
    w_r   <= w_nxt;
  end

  // Little-endian byte read of the finished block
  always_comb begin
    case (rd_pos[1:0])
      2'd0:    rd_byte = w_r[rd_pos[5:2]][7:0];
      2'd1:    rd_byte = w_r[rd_pos[5:2]][15:8];
      2'd2:    rd_byte = w_r[rd_pos[5:2]][23:16];
      default: rd_byte = w_r[rd_pos[5:2]][31:24];
    endcase
  end

  assign sts.busy = (cs_r != CS_IDLE);

`include "chacha20_keystream_xor_macros.svh"

  `CC_ASSERT(a_start_idle, ctl.start |-> cs_r == CS_IDLE, "block start while engine busy")
  `CC_ASSERT(a_rnd_range, rnd_r <= cc20_pkg::RND_LAST, "round counter out of range")
  `CC_ASSERT(a_feed_entry, (cs_r == CS_FEED && stp_r == 2'd0) |-> $past(cs_r) == CS_ROUND,
             "feed-forward entered without finishing rounds")

endmodule

FILE: rtl/core/chacha20_keystream_xor.sv
// ---------------------------------------------------------------------------
// chacha20_keystream_xor
// Byte-serial ChaCha20 stream cipher: XORs each byte with keystream.
// ---------------------------------------------------------------------------
// Flow: a byte inside a block is XORed with keystream into the output
//   register; the first byte of a block waits for the four-lane
//   quarter-round unit (80 round steps, 4 feed-forward steps, handoff),
//   with input held. Inside a block: 1 byte per cycle unless the output stalls.
// Reset: rst_n (sync, active low) clears session key, block counter and
//   byte position; keystream words are not reset.
module chacha20_keystream_xor (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,    // session_key
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast    // out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GEN  = 2'b10
  } st_t;

  st_t         st_r, st_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] blk_ctr_r, blk_ctr_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  logic              in_acc;
  logic              out_free;
  logic [5:0]        pos_inc;
  logic [5:0]        rd_pos;
  logic [7:0]        ks_byte;
  cc20_pkg::cc_ctl_t core_ctl;
  cc20_pkg::cc_sts_t core_sts;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (st_r == ST_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign pos_inc    = pos_r + 6'd1;
  assign rd_pos     = (st_r == ST_GEN) ? '0 : pos_r;

  assign core_ctl.start = in_acc && (pos_r == '0);
  assign core_ctl.key   = key_r;
  assign core_ctl.ctr   = blk_ctr_r;

  cc20_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (core_ctl),
    .sts     (core_sts),
    .rd_pos  (rd_pos),
    .rd_byte (ks_byte)
  );

  // Sequencer, position tracking and output register
  always_comb begin
    st_nxt        = st_r;
    key_nxt       = key_r;
    blk_ctr_nxt   = blk_ctr_r;
    pos_nxt       = pos_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      key_nxt = cfg_data;
    end

    // Byte position advances on each accepted byte, the block counter when it wraps; a last byte clears both
    if (in_acc) begin
      if (in_tlast) begin
        pos_nxt     = '0;
        blk_ctr_nxt = '0;
      end else begin
        pos_nxt = pos_inc;
        if (pos_inc == '0) begin
          blk_ctr_nxt = blk_ctr_r + 32'd1;
        end
      end
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_r == '0) begin
            data_nxt = in_tdata;
            last_nxt = in_tlast;
            st_nxt   = ST_GEN;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = in_tdata ^ ks_byte;
            out_last_nxt  = in_tlast;
          end
        end
      end
      ST_GEN: begin
        if (!core_sts.busy && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r ^ ks_byte;
          out_last_nxt  = last_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      key_r       <= '0;
      blk_ctr_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      key_r       <= key_nxt;
      blk_ctr_r   <= blk_ctr_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`include "chacha20_keystream_xor_macros.svh"

  `CC_ASSERT(a_block_start, (in_acc && pos_r == '0) |=> st_r == ST_GEN,
             "first byte of block did not start generation")
  `CC_ASSERT(a_last_clears, (in_acc && in_tlast) |=> (pos_r == '0 && blk_ctr_r == '0),
             "message end did not clear position and counter")
  `CC_ASSERT(a_idle_core, st_r == ST_IDLE |-> !core_sts.busy,
             "engine busy while stream side idle")

endmodule
